### rtl/button_press_classifier_top_defines.svh
// Assertion macros used by bpc_seq, the sequencer of the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_DEFINES_SVH

`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bpc_pkg.sv
package bpc_pkg;

  localparam int BUTTON_COUNT = 8;
  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int MASK_W = 8;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int EV_W = 2;
  localparam int BTN_W = 3;
  localparam int REG_IDX_W = 2;

  typedef logic [IDX_W-1:0] bidx_t;

  localparam bidx_t LAST_IDX = bidx_t'(BUTTON_COUNT - 1);

  typedef enum logic [EV_W-1:0] {
    EV_NONE,
    EV_SINGLE,
    EV_DOUBLE,
    EV_LONG
  } ev_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEBOUNCE,
    REG_LONG_PRESS,
    REG_DOUBLE_WINDOW
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HELD,
    S_REL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_window_ms;
  } cfg_t;

  typedef struct packed {
    logic lt_debounce;
    logic ge_long;
    logic lt_window;
  } cmp_t;

endpackage

### rtl/bpc_if.sv
interface bpc_poll_if;
  logic                        valid;
  logic                        ready;
  logic [bpc_pkg::MASK_W-1:0]  pressed_mask;
  logic [bpc_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output pressed_mask, output now_ms, input ready);
  modport sink (input valid, input pressed_mask, input now_ms, output ready);
endinterface

interface bpc_result_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::EV_W-1:0]   event_code;
  logic [bpc_pkg::BTN_W-1:0]  button_index;

  modport source (output valid, output event_code, output button_index, input ready);
  modport sink (input valid, input event_code, input button_index, output ready);
endinterface

interface bpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpc_pkg::REG_IDX_W-1:0]  index;
  logic [bpc_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/bpc_diff_unit.sv
module bpc_diff_unit (
  input  logic [bpc_pkg::TIME_W-1:0] now_time,
  input  logic [bpc_pkg::TIME_W-1:0] ref_time,
  input  bpc_pkg::cfg_t              cfg,
  output bpc_pkg::cmp_t              cmp
);
  import bpc_pkg::*;

  logic [TIME_W-1:0] diff;

  assign diff = now_time - ref_time;

  always_comb begin
    cmp.lt_debounce = diff < TIME_W'(cfg.debounce_ms);
    cmp.ge_long     = diff >= TIME_W'(cfg.long_press_ms);
    cmp.lt_window   = diff < TIME_W'(cfg.double_window_ms);
  end
endmodule

### rtl/bpc_seq.sv
`include "button_press_classifier_top_defines.svh"

module bpc_seq (
  input  logic                       clk,
  input  logic                       rst,
  bpc_poll_if.sink                   poll,
  bpc_result_if.source               result,
  output logic [bpc_pkg::TIME_W-1:0] now_time,
  output logic [bpc_pkg::TIME_W-1:0] ref_time,
  input  bpc_pkg::cmp_t              cmp
);
  import bpc_pkg::*;

  state_t              state;
  state_t              state_next;
  bidx_t               idx;
  logic [MASK_W-1:0]   mask;
  logic [TIME_W-1:0]   now_val;
  logic                held_lt_debounce;
  logic                held_ge_long;
  ev_t                 pend_code;
  bidx_t               pend_index;
  logic                res_valid;
  ev_t                 res_code;
  logic [BTN_W-1:0]    res_index;

  logic                was_pressed [BUTTON_COUNT];
  logic [TIME_W-1:0]   start_time [BUTTON_COUNT];
  logic [TIME_W-1:0]   release_time [BUTTON_COUNT];
  logic                single_pending [BUTTON_COUNT];

  logic                cur;
  logic                start_zero;
  ev_t                 ev;
  logic                wp_next;
  logic [TIME_W-1:0]   st_next;
  logic [TIME_W-1:0]   rl_next;
  logic                sp_next;

  assign poll.ready          = (state == S_IDLE) && !rst;
  assign result.valid        = res_valid;
  assign result.event_code   = res_code;
  assign result.button_index = res_index;
  assign now_time            = now_val;
  assign ref_time            = (state == S_HELD) ? start_time[idx] : release_time[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cur        = (32'(idx) < 32'(MASK_W)) ? mask[3'(idx)] : 1'b0;
    start_zero = (start_time[idx] == '0);
    ev         = EV_NONE;
    wp_next    = was_pressed[idx];
    st_next    = start_time[idx];
    rl_next    = release_time[idx];
    sp_next    = single_pending[idx];

    if (cur != was_pressed[idx]) begin
      if (cur) begin
        if (start_zero || !held_lt_debounce) begin
          st_next = now_val;
          wp_next = 1'b1;
          if (single_pending[idx] && cmp.lt_window) begin
            sp_next = 1'b0;
            ev      = EV_DOUBLE;
          end
        end
      end else begin
        wp_next = 1'b0;
        rl_next = now_val;
        sp_next = 1'b1;
        if (start_zero) begin
          sp_next = 1'b0;
        end else if (!held_lt_debounce && held_ge_long) begin
          sp_next = 1'b0;
          ev      = EV_LONG;
        end
      end
    end else if (cur && !start_zero && held_ge_long) begin
      st_next = '0;
      sp_next = 1'b0;
      ev      = EV_LONG;
    end else if (single_pending[idx] && !cmp.lt_window) begin
      sp_next = 1'b0;
      ev      = EV_SINGLE;
    end

    state_next = state;
    case (state)
      S_IDLE: begin
        if (poll.valid) begin
          state_next = S_HELD;
        end
      end
      S_HELD: begin
        state_next = S_REL;
      end
      S_REL: begin
        if (ev != EV_NONE || idx == LAST_IDX) begin
          state_next = S_DONE;
        end else begin
          state_next = S_HELD;
        end
      end
      S_DONE: begin
        if (!res_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        was_pressed[i]    <= 1'b0;
        start_time[i]     <= '0;
        release_time[i]   <= '0;
        single_pending[i] <= 1'b0;
      end
    end else begin
      if (state == S_REL) begin
        was_pressed[idx]    <= wp_next;
        start_time[idx]     <= st_next;
        release_time[idx]   <= rl_next;
        single_pending[idx] <= sp_next;
      end
      if (state == S_DONE && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (poll.valid) begin
          mask    <= poll.pressed_mask;
          now_val <= poll.now_ms;
          idx     <= '0;
        end
      end
      S_HELD: begin
        held_lt_debounce <= cmp.lt_debounce;
        held_ge_long     <= cmp.ge_long;
      end
      S_REL: begin
        pend_code  <= ev;
        pend_index <= (ev == EV_NONE) ? bidx_t'(0) : idx;
        if (ev == EV_NONE && idx != LAST_IDX) begin
          idx <= idx + bidx_t'(1);
        end
      end
      S_DONE: begin
        if (!res_valid || result.ready) begin
          res_code  <= pend_code;
          res_index <= BTN_W'(pend_index);
        end
      end
      default: begin
      end
    endcase
  end

  `BPC_ASSERT_NEXT(a_step_next_button,
    (state == S_REL && ev == EV_NONE && idx != LAST_IDX),
    (state == S_HELD && idx == $past(idx) + bidx_t'(1)),
    "scan did not move to the next button")
  `BPC_ASSERT_NEXT(a_result_loaded,
    (state == S_DONE && (!res_valid || result.ready)),
    (res_valid && state == S_IDLE),
    "finished poll did not load the result register")
  `BPC_ASSERT_NOW(a_none_index_zero,
    (res_valid && res_code == EV_NONE),
    (res_index == '0),
    "no-event result carries a nonzero button")
endmodule

### rtl/button_press_classifier_top.sv
// Each button visited takes a difference state (S_HELD), then a decision state (S_REL); S_DONE
// loads the result. The scan stops at the first button with an event, or after the last button.
// A new poll beat is taken only once the previous scan has loaded its result into the output
// register; the shared subtract-and-compare unit sets the pace.
// A finished result waits in the output register while the next poll is taken.
// Synchronous reset clears all button state, restores the register defaults 50, 1000 and 300.
module button_press_classifier_top (
  input  logic         clk,
  input  logic         rst,
  bpc_poll_if.sink     poll,
  bpc_result_if.source result,
  bpc_cfg_if.sink      cfg
);
  import bpc_pkg::*;

  cfg_t              cfg_regs;
  cmp_t              cmp;
  logic [TIME_W-1:0] now_time;
  logic [TIME_W-1:0] ref_time;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_ms      <= CFG_W'(50);
      cfg_regs.long_press_ms    <= CFG_W'(1000);
      cfg_regs.double_window_ms <= CFG_W'(300);
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_DEBOUNCE:      cfg_regs.debounce_ms      <= cfg.data;
        REG_LONG_PRESS:    cfg_regs.long_press_ms    <= cfg.data;
        REG_DOUBLE_WINDOW: cfg_regs.double_window_ms <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  bpc_diff_unit u_diff (
    .now_time (now_time),
    .ref_time (ref_time),
    .cfg      (cfg_regs),
    .cmp      (cmp)
  );

  bpc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .poll     (poll),
    .result   (result),
    .now_time (now_time),
    .ref_time (ref_time),
    .cmp      (cmp)
  );
endmodule

### tb/bpc_result_checker.sv
module bpc_result_checker import bpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  bpc_poll_if    poll,
  bpc_result_if  result,
  bpc_cfg_if     cfg,
  output int     fail_count,
  output int     backlog,
  output int     results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ev_t              code;
    logic [BTN_W-1:0] btn;
  } press_event_t;

  cfg_t              settings;
  bit                was_down     [BUTTON_COUNT];
  logic [TIME_W-1:0] press_start  [BUTTON_COUNT];
  logic [TIME_W-1:0] release_at   [BUTTON_COUNT];
  bit                single_armed [BUTTON_COUNT];
  press_event_t      predicted_events [$];

  function automatic ev_t visit_button(int b, bit cur, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_rel;
    held = now - press_start[b];
    since_rel = now - release_at[b];
    if (cur != was_down[b]) begin
      if (cur) begin
        if (press_start[b] != '0 && held < settings.debounce_ms) return EV_NONE;
        press_start[b] = now;
        was_down[b] = 1'b1;
        if (single_armed[b] && since_rel < settings.double_window_ms) begin
          single_armed[b] = 1'b0;
          return EV_DOUBLE;
        end
        return EV_NONE;
      end
      was_down[b] = 1'b0;
      release_at[b] = now;
      single_armed[b] = 1'b1;
      if (press_start[b] == '0) begin
        single_armed[b] = 1'b0;
        return EV_NONE;
      end
      if (held < settings.debounce_ms) return EV_NONE;
      if (held >= settings.long_press_ms) begin
        single_armed[b] = 1'b0;
        return EV_LONG;
      end
      return EV_NONE;
    end
    if (cur && press_start[b] != '0 && held >= settings.long_press_ms) begin
      press_start[b] = '0;
      single_armed[b] = 1'b0;
      return EV_LONG;
    end
    if (single_armed[b] && since_rel >= settings.double_window_ms) begin
      single_armed[b] = 1'b0;
      return EV_SINGLE;
    end
    return EV_NONE;
  endfunction

  function automatic press_event_t classify_poll(logic [MASK_W-1:0] mask,
                                                 logic [TIME_W-1:0] now);
    press_event_t found;
    ev_t          ev;
    bit           cur;
    found.code = EV_NONE;
    found.btn = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (found.code == EV_NONE) begin
        cur = (b < MASK_W) ? mask[b] : 1'b0;
        ev = visit_button(b, cur, now);
        if (ev != EV_NONE) begin
          found.code = ev;
          found.btn = BTN_W'(b);
        end
      end
    end
    return found;
  endfunction

  // Every poll beat yields exactly one result beat, in the same order.
  always @(posedge clk) begin
    press_event_t want;
    if (rst) begin
      settings.debounce_ms = 16'd50;
      settings.long_press_ms = 16'd1000;
      settings.double_window_ms = 16'd300;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        was_down[b] = 1'b0;
        press_start[b] = '0;
        release_at[b] = '0;
        single_armed[b] = 1'b0;
      end
      predicted_events.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DEBOUNCE:      settings.debounce_ms = cfg.data;
          REG_LONG_PRESS:    settings.long_press_ms = cfg.data;
          REG_DOUBLE_WINDOW: settings.double_window_ms = cfg.data;
          default: ;
        endcase
      end
      if (poll.valid && poll.ready) begin
        predicted_events.push_back(classify_poll(poll.pressed_mask, poll.now_ms));
      end
      if (result.valid && result.ready) begin
        results_seen <= results_seen + 1;
        if (predicted_events.size() == 0) begin
          $display("%0t: unexpected result, expected nothing, got event %0d button %0d",
                   $time, result.event_code, result.button_index);
          fail_count <= fail_count + 1;
        end else begin
          want = predicted_events.pop_front();
          if (result.event_code != want.code || result.button_index != want.btn) begin
            $display("%0t: result mismatch, expected event %0d button %0d, got event %0d button %0d",
                     $time, want.code, want.btn, result.event_code, result.button_index);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    backlog <= predicted_events.size();
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASES = 7;
  localparam int PHASE_POLLS = 300;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   backlog;
  int   results_seen;
  int   send_idle;
  int   recv_idle;
  int   cycles = 0;
  int   polls_sent = 0;
  int   settings_used = 0;
  int   cur_deb;
  int   cur_long;
  int   cur_win;
  logic [MASK_W-1:0] mask_now;
  logic [TIME_W-1:0] clock_ms;

  bpc_poll_if   poll_bus ();
  bpc_result_if result_bus ();
  bpc_cfg_if    cfg_bus ();

  button_press_classifier_top uut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  bpc_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .poll         (poll_bus),
    .result       (result_bus),
    .cfg          (cfg_bus),
    .fail_count   (fail_count),
    .backlog      (backlog),
    .results_seen (results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_poll(input logic [MASK_W-1:0] m, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle) begin
      poll_bus.valid <= 1'b0;
      @(negedge clk);
    end
    poll_bus.valid <= 1'b1;
    poll_bus.pressed_mask <= m;
    poll_bus.now_ms <= t;
    @(posedge clk);
    while (!poll_bus.ready) @(posedge clk);
    @(negedge clk);
    polls_sent++;
  endtask

  task automatic drain();
    poll_bus.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(input int deb, input int lng, input int win);
    drain();
    write_reg(REG_DEBOUNCE, CFG_W'(deb));
    write_reg(REG_LONG_PRESS, CFG_W'(lng));
    write_reg(REG_DOUBLE_WINDOW, CFG_W'(win));
    cfg_bus.valid <= 1'b0;
    cur_deb = deb;
    cur_long = lng;
    cur_win = win;
    settings_used++;
  endtask

  task automatic random_polls(input int count);
    int pick;
    int delta;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(19);
      delta = 0;
      if (pick <= 5) delta = $urandom_range(cur_deb + 2);
      else if (pick <= 11) delta = $urandom_range(2 * cur_win + 2);
      else if (pick <= 16) delta = $urandom_range(2 * cur_long + 2);
      else if (pick == 17) delta = $urandom_range(3);
      else if (pick == 18) delta = $urandom_range(100000);
      if (pick == 19) clock_ms = ($urandom_range(3) == 0) ? '0 : TIME_W'($urandom);
      else clock_ms = clock_ms + TIME_W'(delta);
      pick = $urandom_range(9);
      if (pick <= 5) begin
        mask_now = mask_now ^ MASK_W'(1 << $urandom_range(MASK_W - 1));
      end else if (pick == 8) begin
        mask_now = mask_now ^ MASK_W'(1 << $urandom_range(MASK_W - 1))
                            ^ MASK_W'(1 << $urandom_range(MASK_W - 1));
      end else if (pick == 9) begin
        mask_now = MASK_W'($urandom);
      end
      send_poll(mask_now, clock_ms);
      if ($urandom_range(299) == 0) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    poll_bus.valid = 1'b0;
    poll_bus.pressed_mask = '0;
    poll_bus.now_ms = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    result_bus.ready = 1'b0;
    send_idle = 16;
    recv_idle = 84;
    cur_deb = 50;
    cur_long = 1000;
    cur_win = 300;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A press at time zero is never timed, so neither the hold nor the release reports.
    send_poll(8'h01, 32'd0);
    send_poll(8'h01, 32'd2000);
    send_poll(8'h00, 32'd2100);
    send_poll(8'h02, 32'd5000);
    send_poll(8'h00, 32'd5100);
    send_poll(8'h02 ^ 8'h02, 32'd5500);
    send_poll(8'h04, 32'd6000);
    send_poll(8'h00, 32'd6100);
    send_poll(8'h04, 32'd6200);
    send_poll(8'h00, 32'd6300);
    send_poll(8'h00, 32'd7000);
    // A second press inside the debounce time is ignored outright.
    send_poll(8'h08, 32'd8000);
    send_poll(8'h00, 32'd8010);
    send_poll(8'h08, 32'd8020);
    send_poll(8'h00, 32'd8400);
    send_poll(8'h80, 32'd9000);
    send_poll(8'h80, 32'd10000);
    send_poll(8'h00, 32'd10100);
    send_poll(8'h10, 32'd11000);
    send_poll(8'h00, 32'd12500);
    // The hold spans the wrap of the millisecond counter.
    send_poll(8'h20, 32'hFFFF_FFF0);
    send_poll(8'h00, 32'h0000_0050);
    send_poll(8'h00, 32'h0000_0400);
    send_poll(8'hFF, 32'h0000_1000);
    send_poll(8'h00, 32'h0000_1100);
    send_poll(8'h00, 32'h0000_1500);
    send_poll(8'h00, 32'h0000_1501);
    send_poll(8'h00, 32'h0000_1502);
    mask_now = '0;
    clock_ms = 32'h0000_1600;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(50, 1000, 300);
        1: apply_settings(0, 0, 0);
        2: apply_settings(65535, 65535, 65535);
        3: apply_settings(1, 1, 1);
        4: apply_settings(10, 200, 100);
        5: apply_settings(65535, 1, 0);
        default: apply_settings($urandom_range(65535), $urandom_range(65535),
                                $urandom_range(65535));
      endcase
      if (p < 2) begin
        send_idle = 16;
        recv_idle = 84;
      end else if (p < 4) begin
        send_idle = 84;
        recv_idle = 16;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_polls(PHASE_POLLS);
    end
    drain();

    $display("Sent %0d polls under %0d register settings and checked %0d results.",
             polls_sent, settings_used, results_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
